// ===== hw/rtl/gcs_pkg.sv =====
// Package for the gray contrast stretch block: weights, widths, datapath
// operation codes and the control structure shared by the sequencer and datapath.
// Depends on nothing.
`default_nettype none

package gcs_pkg;

    // Pixel and accumulator widths.
    localparam int PIX_W = 8;
    localparam int WEIGHT_W = 16;
    localparam int ACC_W = PIX_W + WEIGHT_W;

    // Q16 luma weights; they sum to 65536, so gray never exceeds 255.
    localparam logic [WEIGHT_W-1:0] WEIGHT_RED = 16'd19595;
    localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN = 16'd38470;
    localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE = 16'd7471;

    // Reset values of the running extremes.
    localparam logic [PIX_W-1:0] LOWEST_RESET = 8'd255;
    localparam logic [PIX_W-1:0] HIGHEST_RESET = 8'd0;

    // Step counts of the two iterative phases.
    localparam int MAC_STEPS = 3;
    localparam int DIV_STEPS = PIX_W;
    localparam int CNT_W = 3;

    // Colour channel selected for a multiply-accumulate step.
    localparam logic [1:0] SEL_RED = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE = 2'd2;

    // Datapath operations.
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_MAC_FIRST = 3'd1;
    localparam logic [2:0] OP_MAC = 3'd2;
    localparam logic [2:0] OP_LOAD_DIV = 3'd3;
    localparam logic [2:0] OP_DIV_STEP = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] sel;
    } ctrl_t;

    typedef struct packed {
        logic gray;
        logic quo;
    } emit_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gray_contrast_stretch.sv =====
// Min/max contrast stretch on gray pixels.
// The pixel channel (pixel_valid, pixel_ready) takes one word of mode,
// frame_start and red, green and blue bytes. The result channel
// (result_valid, result_ready) returns one word of value and flat per pixel.
// Each pixel is turned into gray by three multiply-accumulate steps on one
// shared 16 by 8 bit multiplier. A measure word (mode 0) then updates the
// running minimum and maximum and returns gray. A stretch word (mode 1)
// instead runs an 8-step restoring divider for the quotient. A stretch word
// on a flat stored range passes gray through with flat set.
// The block takes one pixel at a time; pixel_ready is high only while it is
// idle. A finished word waits in the output register, so the next pixel is
// accepted and worked on while the receiver stalls; that pixel is held at its
// last step until the output register is free.
// Reset empties the output register, returns the sequencer to idle and sets
// the minimum to 255 and the maximum to 0.
// Depends on gcs_pkg, gcs_seq and gcs_datapath.
`default_nettype none

module gray_contrast_stretch (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        pixel_valid,
    output logic       pixel_ready,
    input  wire        mode,
    input  wire        frame_start,
    input  wire [7:0]  red,
    input  wire [7:0]  green,
    input  wire [7:0]  blue,
    output logic       result_valid,
    input  wire        result_ready,
    output logic [7:0] value,
    output logic       flat
);

    localparam int PW = gcs_pkg::PIX_W;

    logic          in_fire;
    logic          out_free;
    logic          is_flat;
    gcs_pkg::ctrl_t ctrl;
    gcs_pkg::emit_t emit;
    logic [PW-1:0] gray;
    logic [PW-1:0] quotient;

    logic          mode_reg;
    logic          start_reg;
    logic [PW-1:0] red_reg, green_reg, blue_reg;
    logic [PW-1:0] lowest_reg, lowest_next;
    logic [PW-1:0] highest_reg, highest_next;
    logic [PW-1:0] low_base, high_base;
    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] value_reg;
    logic          flat_reg;

    assign in_fire = pixel_valid && pixel_ready;
    assign out_free = !out_valid_reg || result_ready;
    assign is_flat = (lowest_reg == highest_reg);

    gcs_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .mode     (mode_reg),
        .is_flat  (is_flat),
        .out_free (out_free),
        .ctrl     (ctrl),
        .emit     (emit),
        .in_ready (pixel_ready)
    );

    gcs_datapath u_datapath (
        .clk      (clk),
        .ctrl     (ctrl),
        .red      (red_reg),
        .green    (green_reg),
        .blue     (blue_reg),
        .lowest   (lowest_reg),
        .highest  (highest_reg),
        .gray     (gray),
        .quotient (quotient)
    );

    // Input word capture.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= mode;
            start_reg <= frame_start;
            red_reg <= red;
            green_reg <= green;
            blue_reg <= blue;
        end
    end

    // Running extremes, restarted by a frame start in measure mode.
    always_comb
    begin
        low_base = start_reg ? gcs_pkg::LOWEST_RESET : lowest_reg;
        high_base = start_reg ? gcs_pkg::HIGHEST_RESET : highest_reg;
        lowest_next = lowest_reg;
        highest_next = highest_reg;
        if (emit.gray && !mode_reg)
        begin
            lowest_next = (gray < low_base) ? gray : low_base;
            highest_next = (gray > high_base) ? gray : high_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg <= gcs_pkg::LOWEST_RESET;
            highest_reg <= gcs_pkg::HIGHEST_RESET;
        end
        else
        begin
            lowest_reg <= lowest_next;
            highest_reg <= highest_next;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit.gray || emit.quo)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // A gray word in stretch mode only leaves through the flat path.
    always_ff @(posedge clk)
    begin
        if (emit.gray)
        begin
            value_reg <= gray;
            flat_reg <= mode_reg;
        end
        else if (emit.quo)
        begin
            value_reg <= quotient;
            flat_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign value = value_reg;
    assign flat = flat_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gcs_datapath.sv =====
// Shared datapath of the gray contrast stretch block: a multiply-accumulate
// used once per colour channel and a restoring divider used once per quotient bit.
// Depends on gcs_pkg.
`default_nettype none

module gcs_datapath (
    input  wire                         clk,
    input  gcs_pkg::ctrl_t              ctrl,
    input  wire [gcs_pkg::PIX_W-1:0]    red,
    input  wire [gcs_pkg::PIX_W-1:0]    green,
    input  wire [gcs_pkg::PIX_W-1:0]    blue,
    input  wire [gcs_pkg::PIX_W-1:0]    lowest,
    input  wire [gcs_pkg::PIX_W-1:0]    highest,
    output logic [gcs_pkg::PIX_W-1:0]   gray,
    output logic [gcs_pkg::PIX_W-1:0]   quotient
);

    localparam int PW = gcs_pkg::PIX_W;
    localparam int AW = gcs_pkg::ACC_W;

    logic [AW-1:0]           acc_reg, acc_next;
    logic [PW-1:0]           rem_reg, rem_next;
    logic [PW-1:0]           quo_reg, quo_next;
    logic [PW-1:0]           div_reg, div_next;

    logic [PW-1:0]           byte_sel;
    logic [gcs_pkg::WEIGHT_W-1:0] weight_sel;
    logic [AW-1:0]           product;
    logic [AW-1:0]           acc_base;
    logic [PW-1:0]           big, sml, clamped, span;
    logic [PW-1:0]           offset;
    logic [2*PW-1:0]         numer;
    logic [PW:0]             trial;
    logic [PW+1:0]           diff;
    logic                    fits;

    // Channel and weight selection for the multiply-accumulate.
    always_comb
    begin
        case (ctrl.sel)
            gcs_pkg::SEL_RED:
            begin
                byte_sel = red;
                weight_sel = gcs_pkg::WEIGHT_RED;
            end
            gcs_pkg::SEL_GREEN:
            begin
                byte_sel = green;
                weight_sel = gcs_pkg::WEIGHT_GREEN;
            end
            gcs_pkg::SEL_BLUE:
            begin
                byte_sel = blue;
                weight_sel = gcs_pkg::WEIGHT_BLUE;
            end
            default:
            begin
                byte_sel = '0;
                weight_sel = '0;
            end
        endcase
    end

    assign product = AW'(weight_sel) * AW'(byte_sel);
    assign acc_base = (ctrl.op == gcs_pkg::OP_MAC_FIRST) ? '0 : acc_reg;
    assign gray = acc_reg[AW-1:AW-PW];
    assign quotient = quo_reg;

    // Operand preparation. Clamping the gray value into the stored range makes
    // the quotient saturate exactly; an inverted range is measured downwards.
    always_comb
    begin
        big = (highest > lowest) ? highest : lowest;
        sml = (highest > lowest) ? lowest : highest;
        if (gray < sml)
        begin
            clamped = sml;
        end
        else if (gray > big)
        begin
            clamped = big;
        end
        else
        begin
            clamped = gray;
        end
        offset = (highest > lowest) ? (clamped - lowest) : (lowest - clamped);
        span = big - sml;
        numer = {offset, {PW{1'b0}}} - {{PW{1'b0}}, offset};
    end

    // One restoring division step: shift in the next dividend bit and subtract.
    assign trial = {rem_reg, quo_reg[PW-1]};
    assign diff = {1'b0, trial} - {2'b00, div_reg};
    assign fits = ~diff[PW+1];

    always_comb
    begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        div_next = div_reg;
        unique case (ctrl.op) inside
            gcs_pkg::OP_MAC_FIRST, gcs_pkg::OP_MAC:
            begin
                acc_next = acc_base + product;
            end
            gcs_pkg::OP_LOAD_DIV:
            begin
                rem_next = numer[2*PW-1:PW];
                quo_next = numer[PW-1:0];
                div_next = span;
            end
            gcs_pkg::OP_DIV_STEP:
            begin
                rem_next = fits ? diff[PW-1:0] : trial[PW-1:0];
                quo_next = {quo_reg[PW-2:0], fits};
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Datapath registers carry payload only.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gcs_seq.sv =====
// Sequencer of the gray contrast stretch block: steps the shared datapath
// through the gray accumulation, operand preparation and division of one word.
// Depends on gcs_pkg.
`default_nettype none

module gcs_seq (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_fire,
    input  wire             mode,
    input  wire             is_flat,
    input  wire             out_free,
    output gcs_pkg::ctrl_t  ctrl,
    output gcs_pkg::emit_t  emit,
    output logic            in_ready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int CW = gcs_pkg::CNT_W;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ctrl.op = gcs_pkg::OP_NONE;
        ctrl.sel = cnt_reg[1:0];
        emit = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_MAC;
                    cnt_next = '0;
                end
            end
            S_MAC:
            begin
                ctrl.op = (cnt_reg == '0) ? gcs_pkg::OP_MAC_FIRST : gcs_pkg::OP_MAC;
                if (cnt_reg == CW'(gcs_pkg::MAC_STEPS - 1))
                begin
                    state_next = S_PREP;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_PREP:
            begin
                // Measure words and flat ranges finish with the gray value.
                if (!mode || is_flat)
                begin
                    if (out_free)
                    begin
                        emit.gray = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ctrl.op = gcs_pkg::OP_LOAD_DIV;
                    state_next = S_DIV;
                    cnt_next = '0;
                end
            end
            S_DIV:
            begin
                ctrl.op = gcs_pkg::OP_DIV_STEP;
                if (cnt_reg == CW'(gcs_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_DONE;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit.quo = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    // State and step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/gray_contrast_stretch_test.sv =====
// Self-checking testbench for gray_contrast_stretch: directed table, then random
// measure and stretch frames, with idling, a long receiver stall and a predictor.
// Depends on gcs_pkg and the gray_contrast_stretch RTL.
`timescale 1ns / 1ps

module gray_contrast_stretch_test;

    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 9;
    localparam int DIRECTED_N = 21;
    localparam int TOTAL_WORDS = 1850;
    localparam int IDLE_PERCENT = 13;
    localparam int QUIET_FROM = 900;
    localparam int QUIET_TO = 1200;
    localparam int HOLD_AT_WORD = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int MAX_REPORTS = 10;
    localparam int FULL_SCALE = 255;

    localparam logic MODE_MEASURE = 1'b0;
    localparam logic MODE_STRETCH = 1'b1;

    typedef struct packed {
        logic       mode;
        logic       frame_start;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] value;
        logic       flat;
    } gray_word_t;

    typedef struct packed {
        pixel_t     pix;
        logic       typed;
        gray_word_t want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       pixel_valid = 1'b0;
    logic       pixel_ready;
    logic       mode = 1'b0;
    logic       frame_start = 1'b0;
    logic [7:0] red = 8'd0;
    logic [7:0] green = 8'd0;
    logic [7:0] blue = 8'd0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] value;
    logic       flat;

    // Running extremes held by the predictor.
    logic [7:0] run_lowest;
    logic [7:0] run_highest;

    gray_word_t expected_words[$];
    int         words_sent = 0;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    // Directed words; a typed result is checked as written, the rest against the predictor.
    stim_row_t directed_rows [DIRECTED_N] = '{
        // Nothing measured since reset: inverted range gives 255 - gray.
        '{'{MODE_STRETCH, 1'b0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd255, 1'b0}},
        // Frame start is ignored in stretch mode.
        '{'{MODE_STRETCH, 1'b1, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 1'b0}},
        '{'{MODE_MEASURE, 1'b1, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 1'b0}},
        '{'{MODE_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 1'b0}},
        // Full range maps gray onto itself.
        '{'{MODE_STRETCH, 1'b0, 8'd128, 8'd128, 8'd128}, 1'b1, '{8'd128, 1'b0}},
        '{'{MODE_STRETCH, 1'b0, 8'd255, 8'd0, 8'd0}, 1'b0, '{8'd0, 1'b0}},
        '{'{MODE_STRETCH, 1'b0, 8'd0, 8'd255, 8'd0}, 1'b0, '{8'd0, 1'b0}},
        '{'{MODE_STRETCH, 1'b0, 8'd0, 8'd0, 8'd255}, 1'b0, '{8'd0, 1'b0}},
        // A single measured pixel leaves min equal to max; flat stays low here.
        '{'{MODE_MEASURE, 1'b1, 8'd100, 8'd100, 8'd100}, 1'b1, '{8'd100, 1'b0}},
        '{'{MODE_STRETCH, 1'b0, 8'd50, 8'd50, 8'd50}, 1'b1, '{8'd50, 1'b1}},
        '{'{MODE_STRETCH, 1'b1, 8'd200, 8'd200, 8'd200}, 1'b1, '{8'd200, 1'b1}},
        '{'{MODE_MEASURE, 1'b0, 8'd120, 8'd120, 8'd120}, 1'b1, '{8'd120, 1'b0}},
        // Below and above the measured range saturate.
        '{'{MODE_STRETCH, 1'b0, 8'd90, 8'd90, 8'd90}, 1'b1, '{8'd0, 1'b0}},
        '{'{MODE_STRETCH, 1'b0, 8'd250, 8'd250, 8'd250}, 1'b1, '{8'd255, 1'b0}},
        '{'{MODE_STRETCH, 1'b0, 8'd110, 8'd110, 8'd110}, 1'b0, '{8'd0, 1'b0}},
        '{'{MODE_STRETCH, 1'b1, 8'd17, 8'd201, 8'd66}, 1'b0, '{8'd0, 1'b0}},
        '{'{MODE_MEASURE, 1'b1, 8'd255, 8'd0, 8'd255}, 1'b0, '{8'd0, 1'b0}},
        '{'{MODE_MEASURE, 1'b0, 8'd0, 8'd255, 8'd0}, 1'b0, '{8'd0, 1'b0}},
        '{'{MODE_STRETCH, 1'b0, 8'd170, 8'd85, 8'd170}, 1'b0, '{8'd0, 1'b0}},
        '{'{MODE_MEASURE, 1'b0, 8'd170, 8'd170, 8'd170}, 1'b0, '{8'd0, 1'b0}},
        '{'{MODE_STRETCH, 1'b0, 8'd85, 8'd170, 8'd85}, 1'b0, '{8'd0, 1'b0}}
    };

    gray_contrast_stretch u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .mode         (mode),
        .frame_start  (frame_start),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .flat         (flat)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Both sides run without idling inside this window of accepted words.
    function automatic bit quiet_now();
        return (words_sent >= QUIET_FROM) && (words_sent < QUIET_TO);
    endfunction

    // Works out the result word of one pixel and advances the running extremes.
    function automatic gray_word_t stretch_predict(input pixel_t pix);
        gray_word_t  res;
        int unsigned acc;
        int          gray;
        int          num;
        int          den;
        int          quo;
        acc = int'(gcs_pkg::WEIGHT_RED) * pix.red + int'(gcs_pkg::WEIGHT_GREEN) * pix.green
              + int'(gcs_pkg::WEIGHT_BLUE) * pix.blue;
        gray = int'((acc >> 16) & 32'hFF);
        res.flat = 1'b0;
        if (pix.mode == MODE_MEASURE)
        begin
            if (pix.frame_start)
            begin
                run_lowest = gcs_pkg::LOWEST_RESET;
                run_highest = gcs_pkg::HIGHEST_RESET;
            end
            if (gray < run_lowest)
                run_lowest = gray[7:0];
            if (gray > run_highest)
                run_highest = gray[7:0];
            res.value = gray[7:0];
        end
        else if (run_lowest == run_highest)
        begin
            res.value = gray[7:0];
            res.flat = 1'b1;
        end
        else
        begin
            num = (gray - int'(run_lowest)) * FULL_SCALE;
            den = int'(run_highest) - int'(run_lowest);
            quo = num / den;
            // Division truncates towards zero; step down to the floor.
            if ((num % den != 0) && ((num < 0) != (den < 0)))
                quo = quo - 1;
            if (quo < 0)
                quo = 0;
            if (quo > FULL_SCALE)
                quo = FULL_SCALE;
            res.value = quo[7:0];
        end
        return res;
    endfunction

    // A grey level within the band most of the time, otherwise any colour.
    function automatic pixel_t pick_pixel(input int band_lo, input int band_hi);
        pixel_t pix;
        int     level;
        if ($urandom_range(9) < 7)
        begin
            level = $urandom_range(band_hi, band_lo);
            pix.red = level[7:0];
            pix.green = level[7:0];
            pix.blue = level[7:0];
        end
        else
        begin
            pix.red = 8'($urandom_range(255));
            pix.green = 8'($urandom_range(255));
            pix.blue = 8'($urandom_range(255));
        end
        pix.mode = MODE_MEASURE;
        pix.frame_start = 1'b0;
        return pix;
    endfunction

    // Offers one word, waits for it to be taken and queues its expected result.
    task automatic offer_word(input pixel_t pix, input logic typed, input gray_word_t want);
        gray_word_t predicted;
        if (!quiet_now())
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                pixel_valid = 1'b0;
                @(negedge clk);
            end
        end
        mode = pix.mode;
        frame_start = pix.frame_start;
        red = pix.red;
        green = pix.green;
        blue = pix.blue;
        pixel_valid = 1'b1;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        predicted = stretch_predict(pix);
        expected_words.push_back(typed ? want : predicted);
        words_sent++;
        @(negedge clk);
    endtask

    // Stimulus: reset, the directed table, then random frames.
    initial
    begin
        pixel_t pix;
        int     band_lo;
        int     band_hi;
        int     span;
        int     run_len;
        run_lowest = gcs_pkg::LOWEST_RESET;
        run_highest = gcs_pkg::HIGHEST_RESET;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            offer_word(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);

        while (words_sent < TOTAL_WORDS)
        begin
            if ($urandom_range(99) < 8)
            begin
                // Stray word with any mode and flag.
                pix = pick_pixel(0, 255);
                pix.mode = 1'($urandom_range(1));
                pix.frame_start = 1'($urandom_range(1));
                offer_word(pix, 1'b0, '0);
            end
            else
            begin
                band_lo = $urandom_range(255);
                case ($urandom_range(3))
                    0: span = 0;
                    1: span = $urandom_range(8);
                    2: span = $urandom_range(64);
                    default: span = 255;
                endcase
                band_hi = (band_lo + span > 255) ? 255 : band_lo + span;

                // Measure pass, usually opened by a frame start.
                run_len = ($urandom_range(9) == 0) ? $urandom_range(60, 1) : $urandom_range(12, 1);
                for (int i = 0; i < run_len; i++)
                begin
                    pix = pick_pixel(band_lo, band_hi);
                    if (i == 0)
                        pix.frame_start = ($urandom_range(9) != 0);
                    else
                        pix.frame_start = ($urandom_range(49) == 0);
                    offer_word(pix, 1'b0, '0);
                end

                // Stretch pass over a slightly wider band, so some words saturate.
                band_lo = (band_lo > 16) ? band_lo - 16 : 0;
                band_hi = (band_hi < 239) ? band_hi + 16 : 255;
                run_len = $urandom_range(16, 1);
                for (int i = 0; i < run_len; i++)
                begin
                    pix = pick_pixel(band_lo, band_hi);
                    pix.mode = MODE_STRETCH;
                    pix.frame_start = 1'($urandom_range(1));
                    offer_word(pix, 1'b0, '0);
                end
            end
        end
        pixel_valid = 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stalls, one long hold-off to back the block up, and a quiet window.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ready = 1'b0;
                hold_left--;
            end
            else if (!hold_done && words_sent >= HOLD_AT_WORD)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                result_ready = 1'b0;
            end
            else
            begin
                result_ready = quiet_now() || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Result checker: each word taken is compared with the oldest expectation.
    always @(posedge clk)
    begin
        gray_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_words.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result word: value %0d flat %0b", value, flat);
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (value !== want.value || flat !== want.flat)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("mismatch: expected value %0d flat %0b, got value %0d flat %0b",
                                 want.value, want.flat, value, flat);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== gray_contrast_stretch.f =====
hw/rtl/gcs_pkg.sv
hw/rtl/gcs_datapath.sv
hw/rtl/gcs_seq.sv
hw/rtl/gray_contrast_stretch.sv
tb/gray_contrast_stretch_test.sv
